FILE: rtl/qppd_pkg.sv
`timescale 1ns / 1ps

package qppd_pkg;

   // Field and datapath widths.
   localparam int COUNT_W   = 24;
   localparam int GAIN_W    = 24;
   localparam int ERR_W     = COUNT_W + 1;
   localparam int ACC_W     = 48;
   localparam int FRAC_W    = 16;
   localparam int MAG_W     = ACC_W - FRAC_W;
   localparam int DRIVE_W   = 8;
   localparam int PROD_W    = GAIN_W + ERR_W;
   localparam int SUM_W     = PROD_W + 3;

   // Stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Item kinds carried on the request tuser.
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_EDGE_A  = 2'd1;
   localparam logic [1:0] FUNC_EDGE_B  = 2'd2;
   localparam logic [1:0] FUNC_RESTART = 2'd3;

   // Register indexes (byte address is four times the index).
   localparam logic [CSR_IDX_W-1:0] REG_REFERENCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_NOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PREV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PREV2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_RANGE  = 3'd4;

   // Register reset values.
   localparam logic signed [COUNT_W-1:0] REFERENCE_RESET  = '0;
   localparam logic signed [GAIN_W-1:0]  GAIN_NOW_RESET   = 24'sd271811;
   localparam logic signed [GAIN_W-1:0]  GAIN_PREV_RESET  = -24'sd302010;
   localparam logic signed [GAIN_W-1:0]  GAIN_PREV2_RESET = 24'sd30201;
   localparam logic [DRIVE_W-1:0]        PWM_RANGE_RESET  = 8'd100;

   // Controller settings handed to the PID datapath.
   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_prev;
      logic signed [GAIN_W-1:0] gain_prev2;
      logic [DRIVE_W-1:0]       pwm_range;
   } pid_cfg_type;

   // Controller history handed to the PID datapath.
   typedef struct packed {
      logic signed [ERR_W-1:0] err_one;
      logic signed [ERR_W-1:0] err_two;
      logic signed [ACC_W-1:0] accum;
   } pid_hist_type;

endpackage

FILE: rtl/qppd_pid.sv
`timescale 1ns / 1ps

module qppd_pid (
   input  qppd_pkg::pid_cfg_type              cfg,
   input  qppd_pkg::pid_hist_type             hist,
   input  logic signed [qppd_pkg::ERR_W-1:0]  err,
   output logic signed [qppd_pkg::ACC_W-1:0]  accum_next,
   output logic [qppd_pkg::DRIVE_W-1:0]       drive_fwd,
   output logic [qppd_pkg::DRIVE_W-1:0]       drive_rev
);

   logic signed [qppd_pkg::PROD_W-1:0] prod_now;
   logic signed [qppd_pkg::PROD_W-1:0] prod_prev;
   logic signed [qppd_pkg::PROD_W-1:0] prod_prev2;
   logic signed [qppd_pkg::SUM_W-1:0]  sum;
   logic                               sum_ovf;
   logic [qppd_pkg::ACC_W-1:0]         neg_drive;
   logic [qppd_pkg::MAG_W-1:0]         mag;
   logic [qppd_pkg::DRIVE_W-1:0]       mag_clamped;
   logic                               err_pos;

   // The three weighted error terms, computed side by side.
   assign prod_now   = cfg.gain_now   * err;
   assign prod_prev  = cfg.gain_prev  * hist.err_one;
   assign prod_prev2 = cfg.gain_prev2 * hist.err_two;

   // Incremental sum on top of the previous drive.
   assign sum = {{(qppd_pkg::SUM_W - qppd_pkg::ACC_W){hist.accum[qppd_pkg::ACC_W-1]}},
                 hist.accum}
              + {{(qppd_pkg::SUM_W - qppd_pkg::PROD_W){prod_now[qppd_pkg::PROD_W-1]}},
                 prod_now}
              + {{(qppd_pkg::SUM_W - qppd_pkg::PROD_W){prod_prev[qppd_pkg::PROD_W-1]}},
                 prod_prev}
              + {{(qppd_pkg::SUM_W - qppd_pkg::PROD_W){prod_prev2[qppd_pkg::PROD_W-1]}},
                 prod_prev2};

   // Saturate to the accumulator width: overflow when the upper bits disagree.
   assign sum_ovf = (sum[qppd_pkg::SUM_W-1:qppd_pkg::ACC_W-1] != '0)
                 && (sum[qppd_pkg::SUM_W-1:qppd_pkg::ACC_W-1] != '1);

   always_comb begin
      if (sum_ovf) begin
         accum_next = {sum[qppd_pkg::SUM_W-1], {(qppd_pkg::ACC_W-1){~sum[qppd_pkg::SUM_W-1]}}};
      end else begin
         accum_next = sum[qppd_pkg::ACC_W-1:0];
      end
   end

   // The error sign picks the direction; magnitude is the integer part.
   assign err_pos   = !err[qppd_pkg::ERR_W-1] && (err != '0);
   assign neg_drive = qppd_pkg::ACC_W'(-accum_next);

   always_comb begin
      mag = '0;
      if (err_pos) begin
         if (!accum_next[qppd_pkg::ACC_W-1] && (accum_next != '0)) begin
            mag = qppd_pkg::MAG_W'(accum_next[qppd_pkg::ACC_W-1:qppd_pkg::FRAC_W]);
         end
      end else begin
         if (accum_next[qppd_pkg::ACC_W-1]) begin
            mag = neg_drive[qppd_pkg::ACC_W-1:qppd_pkg::FRAC_W];
         end
      end
   end

   // Clamp to the configured range.
   always_comb begin
      if (mag > qppd_pkg::MAG_W'(cfg.pwm_range)) begin
         mag_clamped = cfg.pwm_range;
      end else begin
         mag_clamped = mag[qppd_pkg::DRIVE_W-1:0];
      end
   end

   assign drive_fwd = err_pos ? mag_clamped : '0;
   assign drive_rev = err_pos ? '0 : mag_clamped;

endmodule

FILE: rtl/quadrature_position_pid_drive_core.sv
`timescale 1ns / 1ps

// Quadrature decoder with an incremental PID position drive. Each request item
// is an encoder edge on channel A or B, a sample tick, or a restart, and yields
// exactly one response item with the position count, the error (reference
// minus position) and the held forward and reverse drive magnitudes. An item
// is taken into an input register and its full update (count step, error, the
// three gain multiplies in parallel, the saturating 48-bit sum and the clamp)
// is written from the input register into the response register, so the block
// accepts one item per clock while the response stream is not stalled; the
// multiply-add-saturate path sets the clock limit.
// Registers on the configuration port should only be written while no item is
// in flight.

module quadrature_position_pid_drive_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [0] enc_a, [1] enc_b, [7:2] zero.
   input  logic [qppd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: [1:0] func.
   input  logic [qppd_pkg::REQ_USER_W-1:0]     req_tuser,
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: [23:0] position_count, [48:24] error_counts, [56:49] drive_forward,
   // [64:57] drive_reverse, [71:65] zero.
   output logic [qppd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qppd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [qppd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [qppd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers.
   logic signed [qppd_pkg::COUNT_W-1:0] reference_ff;
   qppd_pkg::pid_cfg_type               cfg_ff;
   logic [qppd_pkg::CSR_IDX_W-1:0]      csr_idx;
   logic                                csr_wr;

   // Input register.
   logic                                in_vld_ff;
   logic [1:0]                          in_func_ff;
   logic                                in_a_ff;
   logic                                in_b_ff;

   // Block state.
   logic signed [qppd_pkg::COUNT_W-1:0] position_ff;
   logic signed [qppd_pkg::COUNT_W-1:0] position_in;
   qppd_pkg::pid_hist_type              hist_ff;
   qppd_pkg::pid_hist_type              hist_in;
   qppd_pkg::pid_hist_type              hist_use;
   logic [qppd_pkg::DRIVE_W-1:0]        fwd_ff;
   logic [qppd_pkg::DRIVE_W-1:0]        fwd_in;
   logic [qppd_pkg::DRIVE_W-1:0]        rev_ff;
   logic [qppd_pkg::DRIVE_W-1:0]        rev_in;

   // Datapath.
   logic signed [qppd_pkg::ERR_W-1:0]   err;
   logic signed [qppd_pkg::ACC_W-1:0]   pid_accum;
   logic [qppd_pkg::DRIVE_W-1:0]        pid_fwd;
   logic [qppd_pkg::DRIVE_W-1:0]        pid_rev;
   logic                                step_up;
   logic                                advance;

   // Response register.
   logic                                rsp_vld_ff;
   logic [qppd_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic [qppd_pkg::RSP_DATA_W-1:0]     rsp_data_in;

   // The stage moves when the response register is free or being drained.
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;

   // Configuration access.
   assign csr_idx    = csr_paddr[qppd_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         qppd_pkg::REG_REFERENCE:
            csr_prdata = qppd_pkg::CSR_DATA_W'($unsigned(reference_ff));
         qppd_pkg::REG_GAIN_NOW:
            csr_prdata = qppd_pkg::CSR_DATA_W'($unsigned(cfg_ff.gain_now));
         qppd_pkg::REG_GAIN_PREV:
            csr_prdata = qppd_pkg::CSR_DATA_W'($unsigned(cfg_ff.gain_prev));
         qppd_pkg::REG_GAIN_PREV2:
            csr_prdata = qppd_pkg::CSR_DATA_W'($unsigned(cfg_ff.gain_prev2));
         qppd_pkg::REG_PWM_RANGE:
            csr_prdata = qppd_pkg::CSR_DATA_W'(cfg_ff.pwm_range);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff      <= qppd_pkg::REFERENCE_RESET;
         cfg_ff.gain_now   <= qppd_pkg::GAIN_NOW_RESET;
         cfg_ff.gain_prev  <= qppd_pkg::GAIN_PREV_RESET;
         cfg_ff.gain_prev2 <= qppd_pkg::GAIN_PREV2_RESET;
         cfg_ff.pwm_range  <= qppd_pkg::PWM_RANGE_RESET;
      end else if (csr_wr && csr_pready) begin
         unique case (csr_idx)
            qppd_pkg::REG_REFERENCE:
               reference_ff <= csr_pwdata[qppd_pkg::COUNT_W-1:0];
            qppd_pkg::REG_GAIN_NOW:
               cfg_ff.gain_now <= csr_pwdata[qppd_pkg::GAIN_W-1:0];
            qppd_pkg::REG_GAIN_PREV:
               cfg_ff.gain_prev <= csr_pwdata[qppd_pkg::GAIN_W-1:0];
            qppd_pkg::REG_GAIN_PREV2:
               cfg_ff.gain_prev2 <= csr_pwdata[qppd_pkg::GAIN_W-1:0];
            qppd_pkg::REG_PWM_RANGE:
               cfg_ff.pwm_range <= csr_pwdata[qppd_pkg::DRIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser[1:0];
         in_a_ff    <= req_tdata[0];
         in_b_ff    <= req_tdata[1];
      end
   end

   // Count direction: on A up when the levels match, on B up when they differ.
   assign step_up = (in_func_ff == qppd_pkg::FUNC_EDGE_A) ? (in_a_ff == in_b_ff)
                                                          : (in_a_ff != in_b_ff);

   // Position step and history clear ahead of the error and the PID.
   always_comb begin
      position_in = position_ff;
      hist_use    = hist_ff;
      unique case (in_func_ff)
         qppd_pkg::FUNC_EDGE_A, qppd_pkg::FUNC_EDGE_B: begin
            position_in = step_up ? position_ff + qppd_pkg::COUNT_W'(1)
                                  : position_ff - qppd_pkg::COUNT_W'(1);
         end
         qppd_pkg::FUNC_RESTART: begin
            hist_use = '0;
         end
         default: begin
         end
      endcase
   end

   assign err = {reference_ff[qppd_pkg::COUNT_W-1], reference_ff}
              - {position_in[qppd_pkg::COUNT_W-1], position_in};

   qppd_pid u_pid (
      .cfg        (cfg_ff),
      .hist       (hist_use),
      .err        (err),
      .accum_next (pid_accum),
      .drive_fwd  (pid_fwd),
      .drive_rev  (pid_rev)
   );

   // Held drives change only on a sample tick; history also changes on a restart, which clears it.
   always_comb begin
      hist_in = hist_use;
      fwd_in  = fwd_ff;
      rev_in  = rev_ff;
      if (in_func_ff == qppd_pkg::FUNC_TICK) begin
         hist_in.err_two = hist_use.err_one;
         hist_in.err_one = err;
         hist_in.accum   = pid_accum;
         fwd_in          = pid_fwd;
         rev_in          = pid_rev;
      end
   end

   assign rsp_data_in = {{(qppd_pkg::RSP_DATA_W - 2*qppd_pkg::DRIVE_W - qppd_pkg::ERR_W
                           - qppd_pkg::COUNT_W){1'b0}},
                         rev_in, fwd_in, err, position_in};

   // State update and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         position_ff <= '0;
         hist_ff     <= '0;
         fwd_ff      <= '0;
         rev_ff      <= '0;
      end else if (advance) begin
         rsp_vld_ff <= in_vld_ff;
         if (in_vld_ff) begin
            position_ff <= position_in;
            hist_ff     <= hist_in;
            fwd_ff      <= fwd_in;
            rev_ff      <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_vld_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
